FILE: design/jkx_pkg.sv
// ----------------------------------------------------------------------------
// jkx_pkg
// Shared constants, codes and types of the JSON key object extractor.
// ----------------------------------------------------------------------------
package jkx_pkg;

  localparam int PATTERN_BYTES_DEF = 48;
  localparam int NEST_LIMIT_DEF    = 255;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int KEY_REGS  = 6;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_0  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_5  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY = 4'd7;

  localparam logic [5:0]  KEY_LENGTH_RST   = 6'd0;
  localparam logic [15:0] OUT_CAPACITY_RST = 16'd256;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ABSENT   = 3'd1;
  localparam logic [2:0] ST_NOT_OBJ  = 3'd2;
  localparam logic [2:0] ST_CAPACITY = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;
  localparam logic [2:0] ST_NEST     = 3'd5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_OPEN   = 8'h7b;
  localparam logic [7:0] CH_CLOSE  = 8'h7d;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;

  localparam logic [1:0] OP_DATA     = 2'd0;
  localparam logic [1:0] OP_DATA_END = 2'd1;
  localparam logic [1:0] OP_STATUS   = 2'd2;
  localparam logic [1:0] OP_DEFAULT  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [2:0] code;
    logic [1:0] ndef;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

FILE: design/jkx_front.sv
// ----------------------------------------------------------------------------
// jkx_front
// Configuration registers, key window match and document phase tracking.
// Turns each text word into at most one command for the result side.
// ----------------------------------------------------------------------------
module jkx_front #(
  parameter int PATTERN_BYTES = jkx_pkg::PATTERN_BYTES_DEF,
  parameter int NEST_LIMIT    = jkx_pkg::NEST_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jkx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jkx_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                           text_valid,
  output logic                           text_stall,
  input  logic [7:0]                     text_byte,
  input  logic                           q_full,
  output logic                           push,
  output jkx_pkg::cmd_t                  cmd
);

  localparam int W       = PATTERN_BYTES - 1;
  localparam int KEY_MAX = PATTERN_BYTES - 3;
  localparam int SEEN_W  = $clog2(PATTERN_BYTES);
  localparam int LIM     = (NEST_LIMIT < 255) ? NEST_LIMIT : 255;
  localparam logic [7:0] LIM_V = 8'(LIM);

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_COLON  = 3'd1;
  localparam logic [2:0] PH_BLANK  = 3'd2;
  localparam logic [2:0] PH_COPY   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [5:0]                     key_length;
  logic [jkx_pkg::CFG_DAT_W-1:0]  key_regs [jkx_pkg::KEY_REGS];
  logic [15:0]                    out_capacity;

  logic [7:0]        recent [W];
  logic [SEEN_W-1:0] seen;
  logic [2:0]        phase;
  logic [15:0]       copied;
  logic [7:0]        nest;
  logic              in_str;
  logic              esc;

  logic [SEEN_W-1:0] seen_next;
  logic [2:0]        phase_next;
  logic [15:0]       copied_next;
  logic [7:0]        nest_next;
  logic              in_str_next;
  logic              esc_next;

  logic        accept;
  logic        shift_en;
  logic        clear_doc;
  logic        finish;
  logic        do_copy;
  logic        bad_cfg;
  logic        blank;
  logic [6:0]  plen;
  logic [7:0]  key_arr [64];
  logic [7:0]  win [W];
  logic [W-1:0] hit;
  logic        match;
  logic [7:0]  nest_dec;

  assign cfg_ready  = 1'b1;
  assign text_stall = q_full;
  assign accept     = text_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length   <= jkx_pkg::KEY_LENGTH_RST;
      out_capacity <= jkx_pkg::OUT_CAPACITY_RST;
      for (int i = 0; i < jkx_pkg::KEY_REGS; i++) begin
        key_regs[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        jkx_pkg::REG_KEY_LENGTH:   key_length   <= cfg_data[5:0];
        jkx_pkg::REG_OUT_CAPACITY: out_capacity <= cfg_data[15:0];
        default: begin
          if (cfg_index >= jkx_pkg::REG_KEY_BYTES_0 && cfg_index <= jkx_pkg::REG_KEY_BYTES_5)
            key_regs[3'(cfg_index - jkx_pkg::REG_KEY_BYTES_0)] <= cfg_data;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      if (i < 8 * jkx_pkg::KEY_REGS) key_arr[i] = key_regs[i / 8][(i % 8) * 8 +: 8];
      else key_arr[i] = 8'd0;
    end
  end

  assign plen    = 7'(key_length) + 7'd2;
  assign bad_cfg = (out_capacity == 16'd0) || (key_length > 6'(KEY_MAX));

  always_comb begin
    win[0] = text_byte;
    for (int k = 1; k < W; k++) begin
      win[k] = recent[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < W; k++) begin
      if (7'(k) >= plen) hit[k] = 1'b1;
      else if (k == 0 || 7'(k) == plen - 7'd1) hit[k] = (win[k] == jkx_pkg::CH_QUOTE);
      else hit[k] = (win[k] == key_arr[6'(key_length - 6'(k))]);
    end
  end

  always_comb begin
    seen_next = (seen < SEEN_W'(W)) ? seen + SEEN_W'(1) : seen;
  end

  assign match = (plen <= 7'(W)) && (7'(seen_next) >= plen) && (&hit);
  assign blank = (text_byte == jkx_pkg::CH_SPACE) || (text_byte == jkx_pkg::CH_TAB) ||
                 (text_byte == jkx_pkg::CH_CR) || (text_byte == jkx_pkg::CH_LF);
  assign nest_dec = (nest > 8'd0) ? nest - 8'd1 : 8'd0;

  always_comb begin
    phase_next  = phase;
    copied_next = copied;
    nest_next   = nest;
    in_str_next = in_str;
    esc_next    = esc;
    shift_en    = 1'b0;
    clear_doc   = 1'b0;
    finish      = 1'b0;
    do_copy     = 1'b0;
    push        = 1'b0;
    cmd         = '0;
    if (phase == PH_DONE) begin
      clear_doc = (text_byte == jkx_pkg::CH_NUL);
    end else if (bad_cfg) begin
      push     = 1'b1;
      cmd.op   = jkx_pkg::OP_STATUS;
      cmd.code = jkx_pkg::ST_CAPACITY;
      finish   = 1'b1;
    end else begin
      case (phase)
        PH_SEARCH, PH_COLON: begin
          if (text_byte == jkx_pkg::CH_NUL) begin
            push     = 1'b1;
            cmd.op   = jkx_pkg::OP_DEFAULT;
            cmd.code = jkx_pkg::ST_ABSENT;
            cmd.ndef = (out_capacity >= 16'd3) ? 2'd2 :
                       (out_capacity >= 16'd2) ? 2'd1 : 2'd0;
            finish   = 1'b1;
          end else if (phase == PH_SEARCH) begin
            shift_en = 1'b1;
            if (match) phase_next = PH_COLON;
          end else if (text_byte == jkx_pkg::CH_COLON) begin
            phase_next = PH_BLANK;
          end
        end
        PH_BLANK: begin
          if (text_byte == jkx_pkg::CH_OPEN) begin
            phase_next = PH_COPY;
            do_copy    = 1'b1;
          end else if (!blank) begin
            push     = 1'b1;
            cmd.op   = jkx_pkg::OP_STATUS;
            cmd.code = jkx_pkg::ST_NOT_OBJ;
            finish   = 1'b1;
          end
        end
        PH_COPY: do_copy = 1'b1;
        default: do_copy = 1'b0;
      endcase
      if (do_copy) begin
        push           = 1'b1;
        cmd.data_byte  = text_byte;
        if (text_byte == jkx_pkg::CH_NUL) begin
          cmd.op        = jkx_pkg::OP_STATUS;
          cmd.code      = jkx_pkg::ST_TRUNC;
          cmd.data_byte = 8'd0;
          finish        = 1'b1;
        end else if (17'(copied) + 17'd1 >= 17'(out_capacity)) begin
          cmd.op        = jkx_pkg::OP_STATUS;
          cmd.code      = jkx_pkg::ST_CAPACITY;
          cmd.data_byte = 8'd0;
          finish        = 1'b1;
        end else if (!in_str && text_byte == jkx_pkg::CH_OPEN && nest >= LIM_V) begin
          cmd.op        = jkx_pkg::OP_STATUS;
          cmd.code      = jkx_pkg::ST_NEST;
          cmd.data_byte = 8'd0;
          finish        = 1'b1;
        end else begin
          cmd.op      = jkx_pkg::OP_DATA;
          copied_next = copied + 16'd1;
          if (in_str) begin
            if (esc) esc_next = 1'b0;
            else if (text_byte == jkx_pkg::CH_BSLASH) esc_next = 1'b1;
            else if (text_byte == jkx_pkg::CH_QUOTE) in_str_next = 1'b0;
          end else if (text_byte == jkx_pkg::CH_QUOTE) begin
            in_str_next = 1'b1;
          end else if (text_byte == jkx_pkg::CH_OPEN) begin
            nest_next = nest + 8'd1;
          end else if (text_byte == jkx_pkg::CH_CLOSE) begin
            nest_next = nest_dec;
            if (nest_dec == 8'd0) begin
              cmd.op   = jkx_pkg::OP_DATA_END;
              cmd.code = jkx_pkg::ST_OK;
              finish   = 1'b1;
            end
          end
        end
      end
    end
    if (finish) begin
      if (text_byte == jkx_pkg::CH_NUL) clear_doc = 1'b1;
      else phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= '0;
      phase  <= PH_SEARCH;
      copied <= '0;
      nest   <= '0;
      in_str <= 1'b0;
      esc    <= 1'b0;
    end else if (accept) begin
      if (clear_doc) begin
        seen   <= '0;
        phase  <= PH_SEARCH;
        copied <= '0;
        nest   <= '0;
        in_str <= 1'b0;
        esc    <= 1'b0;
      end else begin
        if (shift_en) seen <= seen_next;
        phase  <= phase_next;
        copied <= copied_next;
        nest   <= nest_next;
        in_str <= in_str_next;
        esc    <= esc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && shift_en) begin
      for (int k = 0; k < W; k++) begin
        recent[k] <= win[k];
      end
    end
  end

endmodule

FILE: design/jkx_queue.sv
// ----------------------------------------------------------------------------
// jkx_queue
// Short command queue between the classifying front and the result back.
// ----------------------------------------------------------------------------
module jkx_queue #(
  parameter int DEPTH = jkx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jkx_pkg::cmd_t     push_cmd,
  output logic              full,
  input  logic              pop,
  output jkx_pkg::q_head_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jkx_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

endmodule

FILE: design/jkx_back.sv
// ----------------------------------------------------------------------------
// jkx_back
// Expands queued commands into result words through an output register.
// ----------------------------------------------------------------------------
module jkx_back (
  input  logic              clk,
  input  logic              rst,
  input  jkx_pkg::q_head_t  head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              is_status,
  output logic [7:0]        out_byte,
  output logic [2:0]        status_code,
  output logic              last_of_run
);

  logic [1:0] sub;
  logic       load;
  logic       item_status;
  logic [7:0] item_byte;
  logic [2:0] item_code;
  logic       item_last;

  assign load = head.valid && (!result_valid || !result_stall);
  assign pop  = load && item_last;

  always_comb begin
    item_status = 1'b0;
    item_byte   = head.cmd.data_byte;
    item_code   = jkx_pkg::ST_OK;
    item_last   = 1'b1;
    case (head.cmd.op)
      jkx_pkg::OP_DATA: item_last = 1'b1;
      jkx_pkg::OP_DATA_END: begin
        if (sub == 2'd0) begin
          item_last = 1'b0;
        end else begin
          item_status = 1'b1;
          item_byte   = 8'd0;
        end
      end
      jkx_pkg::OP_DEFAULT: begin
        if (sub < head.cmd.ndef) begin
          item_byte = (sub == 2'd0) ? jkx_pkg::CH_OPEN : jkx_pkg::CH_CLOSE;
          item_last = 1'b0;
        end else begin
          item_status = 1'b1;
          item_byte   = 8'd0;
          item_code   = jkx_pkg::ST_ABSENT;
        end
      end
      default: begin
        item_status = 1'b1;
        item_byte   = 8'd0;
        item_code   = head.cmd.code;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sub          <= '0;
    end else if (load) begin
      result_valid <= 1'b1;
      sub          <= item_last ? 2'd0 : sub + 2'd1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_status   <= item_status;
      out_byte    <= item_byte;
      status_code <= item_code;
      last_of_run <= item_status;
    end
  end

endmodule

FILE: design/json_key_object_extractor.sv
// ----------------------------------------------------------------------------
// json_key_object_extractor
// Finds a quoted key in a text stream and copies the brace object after it.
// A text word's result words pass through the command queue and then the output register.
// Throughput: one text word per cycle unless the queue is full; the queue absorbs the
// extra result words of a closing brace (2) or a missing key (up to 3), sent one per cycle unless stalled.
// Reset: synchronous rst clears control state and restores configuration
// defaults; no clearing pass.
// ----------------------------------------------------------------------------
module json_key_object_extractor #(
  parameter int PATTERN_BYTES = jkx_pkg::PATTERN_BYTES_DEF,
  parameter int NEST_LIMIT    = jkx_pkg::NEST_LIMIT_DEF,
  parameter int QUEUE_DEPTH   = jkx_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jkx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jkx_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                           text_valid,
  output logic                           text_stall,
  input  logic [7:0]                     text_byte,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           is_status,
  output logic [7:0]                     out_byte,
  output logic [2:0]                     status_code,
  output logic                           last_of_run
);

  logic              q_full;
  logic              push;
  logic              pop;
  jkx_pkg::cmd_t     cmd;
  jkx_pkg::q_head_t  head;

  jkx_front #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .NEST_LIMIT    (NEST_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .q_full     (q_full),
    .push       (push),
    .cmd        (cmd)
  );

  jkx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push && text_valid),
    .push_cmd (cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  jkx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_status    (is_status),
    .out_byte     (out_byte),
    .status_code  (status_code),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: design/jkx_checker.sv
// ----------------------------------------------------------------------------
// jkx_checker
// Port-level checks on text and result words of the JSON key object extractor.
// ----------------------------------------------------------------------------
module jkx_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           text_valid,
  input logic                           text_stall,
  input logic [7:0]                     text_byte,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic                           is_status,
  input logic [7:0]                     out_byte,
  input logic [2:0]                     status_code,
  input logic                           last_of_run
);

  a_status_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_status |-> last_of_run && out_byte == 8'd0 &&
      status_code <= jkx_pkg::ST_NEST)
    else $error("status word malformed");

  a_data_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_status |-> !last_of_run && status_code == jkx_pkg::ST_OK)
    else $error("data word malformed");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_byte) &&
      $stable(is_status) && $stable(status_code))
    else $error("stalled result word changed");

  a_text_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_stall |=> text_valid && $stable(text_byte))
    else $error("stalled text word changed");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind json_key_object_extractor jkx_checker u_jkx_checker (.*);
